>>> rtl/nqtd_pkg.sv
// ----------------------------------------------------------------------------
// nqtd_pkg - shared types and constants
// item layouts, status and operation codes, configuration register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package nqtd_pkg;

  localparam int TAIL_W   = 16;
  localparam int STRIDE_W = 11;
  localparam int ASIZE_W  = 13;
  localparam int IOSIZE_W = 17;
  localparam int COUNT_W  = 17;
  localparam int CFG_W    = 17;
  localparam int CFGIDX_W = 2;

  localparam logic [15:0] MASK16 = 16'hFFFF;

  // operation codes
  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_SUBMITTED = 2'd0;
  localparam logic [1:0] ST_COMPLETED = 2'd1;
  localparam logic [1:0] ST_WAITING   = 2'd2;
  localparam logic [1:0] ST_TIMEOUT   = 2'd3;

  // configuration register indexes
  localparam logic [CFGIDX_W-1:0] CFG_DOORBELL_STRIDE  = 2'd0;
  localparam logic [CFGIDX_W-1:0] CFG_ADMIN_QUEUE_SIZE = 2'd1;
  localparam logic [CFGIDX_W-1:0] CFG_IO_QUEUE_SIZE    = 2'd2;

  localparam logic [STRIDE_W-1:0] STRIDE_RST = 11'd4;
  localparam logic [ASIZE_W-1:0]  ASIZE_RST  = 13'd64;
  localparam logic [IOSIZE_W-1:0] IOSIZE_RST = 17'd1024;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic        func;
    logic [4:0]  queue_number;
    logic [15:0] wanted_id;
    logic [15:0] seen_id;
    logic [15:0] poll_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] slot_index;
    logic        doorbell_write;
    logic [15:0] doorbell_offset;
    logic [15:0] doorbell_value;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/nqtd_tail_store.sv
// ----------------------------------------------------------------------------
// nqtd_tail_store - ring tail memory
// one tail pointer per queue, registered read, valid bit per entry
// so that an entry never written reads as zero after reset
// ----------------------------------------------------------------------------
`default_nettype none

module nqtd_tail_store #(
  parameter int DEPTH = 17
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic      [nqtd_pkg::TAIL_W-1:0]       rd_data,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  wire logic [nqtd_pkg::TAIL_W-1:0]       wr_data
);

  logic [nqtd_pkg::TAIL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            valid_r;
  logic [nqtd_pkg::TAIL_W-1:0] rd_data_r;
  logic                        rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> rtl/nvme_queue_tail_doorbell_manager.sv
// ----------------------------------------------------------------------------
// nvme_queue_tail_doorbell_manager - submission / completion doorbell manager
// keeps a ring tail per queue, issues tail and head doorbell writes
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  input     start, busy, in_item                   taken when start && !busy
//  result    out_valid, out_item                    one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data            written when cfg_we
//
//  for an item, the edge that takes it reads the tail memory,
//  the next cycle updates the pointer, forms the doorbell offset with one
//  multiply and writes the tail back; busy is high for that cycle
//  the result strobes in the cycle after, and start may be taken in it
//  reset: synchronous; tails read as zero through per-entry valid bits, so
//  no clearing pass is needed and an item can be taken right after reset
// ----------------------------------------------------------------------------
`default_nettype none

module nvme_queue_tail_doorbell_manager #(
  parameter int MAX_IO_QUEUES = 16,
  parameter int DOORBELL_BASE = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire nqtd_pkg::in_item_t                in_item,
  output logic                                   out_valid,
  output nqtd_pkg::out_item_t                    out_item,
  input  wire logic                              cfg_we,
  input  wire logic [nqtd_pkg::CFGIDX_W-1:0]     cfg_index,
  input  wire logic [nqtd_pkg::CFG_W-1:0]        cfg_data
);

  localparam int NQ     = MAX_IO_QUEUES + 1;
  localparam int QIDX_W = $clog2(NQ);
  localparam int BIDX_W = QIDX_W + 1;
  localparam int PROD_W = BIDX_W + nqtd_pkg::STRIDE_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [nqtd_pkg::STRIDE_W-1:0] stride_r;
  logic [nqtd_pkg::ASIZE_W-1:0]  asize_r;
  logic [nqtd_pkg::IOSIZE_W-1:0] iosize_r;
  logic [nqtd_pkg::COUNT_W-1:0]  count_r, count_nxt;

  nqtd_pkg::in_item_t  item_r;
  logic                in_range_r;
  nqtd_pkg::out_item_t out_item_r, out_item_nxt;
  logic                out_valid_r;

  logic                        accept;
  logic                        in_range;
  logic [QIDX_W-1:0]           q_idx;
  logic [nqtd_pkg::TAIL_W-1:0] tail;
  logic                        wr_en;
  logic [nqtd_pkg::TAIL_W-1:0] wr_data;

  logic [nqtd_pkg::IOSIZE_W-1:0] size;
  logic [nqtd_pkg::IOSIZE_W:0]   next;
  logic [nqtd_pkg::IOSIZE_W-1:0] entry;
  logic [nqtd_pkg::IOSIZE_W:0]   head;
  logic                          match;
  logic [BIDX_W-1:0]             bell_idx;
  logic [PROD_W-1:0]             prod;
  logic [15:0]                   offset;
  logic [nqtd_pkg::COUNT_W-1:0]  count_inc;

  assign busy     = (state_r == S_EXEC);
  assign accept   = start && !busy;
  assign in_range = (32'(in_item.queue_number) <= 32'(MAX_IO_QUEUES));
  assign q_idx    = QIDX_W'(item_r.queue_number);

  nqtd_tail_store #(
    .DEPTH (NQ)
  ) u_tail_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && in_range),
    .rd_addr (QIDX_W'(in_item.queue_number)),
    .rd_data (tail),
    .wr_en   (wr_en),
    .wr_addr (q_idx),
    .wr_data (wr_data)
  );

  // pointer arithmetic, doorbell offset and attempt count
  always_comb begin
    size = (item_r.queue_number == 5'd0) ?
           nqtd_pkg::IOSIZE_W'(asize_r) : iosize_r;

    next = (nqtd_pkg::IOSIZE_W + 1)'(tail) + 1'b1;
    if (next >= {1'b0, size}) begin
      next = '0;
    end

    // last-submitted entry, wrapping backwards past zero
    if (tail != '0) begin
      entry = nqtd_pkg::IOSIZE_W'(tail) - 1'b1;
    end else if (size != '0) begin
      entry = size - 1'b1;
    end else begin
      entry = '0;
    end
    head = {1'b0, entry} + 1'b1;
    if (head >= {1'b0, size}) begin
      head = '0;
    end

    match    = (item_r.seen_id == item_r.wanted_id);
    bell_idx = {q_idx, (item_r.func == nqtd_pkg::FUNC_POLL)};
    prod     = PROD_W'(bell_idx) * PROD_W'(stride_r);
    offset   = 16'(DOORBELL_BASE) + 16'(prod);

    count_inc = (count_r == nqtd_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;

    out_item_nxt = '0;
    count_nxt    = count_r;
    wr_en        = 1'b0;
    wr_data      = next[nqtd_pkg::TAIL_W-1:0] & nqtd_pkg::MASK16;

    if (!in_range_r) begin
      out_item_nxt.status = nqtd_pkg::ST_TIMEOUT;
    end else if (item_r.func == nqtd_pkg::FUNC_SUBMIT) begin
      wr_en                        = busy;
      out_item_nxt.status          = nqtd_pkg::ST_SUBMITTED;
      out_item_nxt.slot_index      = tail;
      out_item_nxt.doorbell_write  = 1'b1;
      out_item_nxt.doorbell_offset = offset;
      out_item_nxt.doorbell_value  = next[15:0];
    end else begin
      out_item_nxt.slot_index = entry[15:0];
      if (match) begin
        count_nxt                    = '0;
        out_item_nxt.status          = nqtd_pkg::ST_COMPLETED;
        out_item_nxt.doorbell_write  = 1'b1;
        out_item_nxt.doorbell_offset = offset;
        out_item_nxt.doorbell_value  = head[15:0];
      end else if (item_r.poll_limit != '0 &&
                   count_inc > nqtd_pkg::COUNT_W'(item_r.poll_limit)) begin
        count_nxt           = '0;
        out_item_nxt.status = nqtd_pkg::ST_TIMEOUT;
      end else begin
        count_nxt           = count_inc;
        out_item_nxt.status = nqtd_pkg::ST_WAITING;
      end
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      stride_r    <= nqtd_pkg::STRIDE_RST;
      asize_r     <= nqtd_pkg::ASIZE_RST;
      iosize_r    <= nqtd_pkg::IOSIZE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (busy) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          nqtd_pkg::CFG_DOORBELL_STRIDE:  stride_r <= cfg_data[nqtd_pkg::STRIDE_W-1:0];
          nqtd_pkg::CFG_ADMIN_QUEUE_SIZE: asize_r  <= cfg_data[nqtd_pkg::ASIZE_W-1:0];
          nqtd_pkg::CFG_IO_QUEUE_SIZE:    iosize_r <= cfg_data[nqtd_pkg::IOSIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= in_item;
      in_range_r <= in_range;
    end
    if (busy) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> bench/doorbell_checker.sv
// ----------------------------------------------------------------------------
// doorbell_checker - result checker for the tail doorbell manager
// watches the item, result and register ports, predicts every result from its
// own copy of the ring tails, attempt count and registers, compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module doorbell_checker #(
  parameter int MAX_IO_QUEUES = 16,
  parameter int DOORBELL_BASE = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  nqtd_pkg::in_item_t                in_item,
  input  logic                              out_valid,
  input  nqtd_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [nqtd_pkg::CFGIDX_W-1:0]     cfg_index,
  input  logic [nqtd_pkg::CFG_W-1:0]        cfg_data,
  output int                                fail_count,
  output int                                pending
);
  import nqtd_pkg::*;

  logic [TAIL_W-1:0]   ring_tails [0:MAX_IO_QUEUES];
  logic [COUNT_W-1:0]  attempts;
  logic [STRIDE_W-1:0] stride;
  logic [ASIZE_W-1:0]  admin_size;
  logic [IOSIZE_W-1:0] io_size;
  out_item_t           due_results [$];
  int                  errors = 0;

  function automatic logic [15:0] bell_offset(int unsigned bell_idx);
    int unsigned raw;
    raw = DOORBELL_BASE + bell_idx * 32'(stride);
    return raw[15:0];
  endfunction

  // advances the tails and the attempt count as the block would
  function automatic out_item_t predict_doorbell(in_item_t it);
    out_item_t   res;
    int unsigned q;
    int unsigned ring_len;
    int unsigned tail;
    int unsigned nxt_tail;
    int unsigned entry;
    int unsigned head;
    res = '0;
    q = 32'(it.queue_number);
    if (q > MAX_IO_QUEUES) begin
      res.status = ST_TIMEOUT;
    end else begin
      ring_len = (q == 0) ? 32'(admin_size) : 32'(io_size);
      tail = 32'(ring_tails[q]);
      if (it.func == FUNC_SUBMIT) begin
        nxt_tail = tail + 1;
        if (nxt_tail >= ring_len) nxt_tail = 0;
        ring_tails[q] = nxt_tail[15:0];
        res.status = ST_SUBMITTED;
        res.slot_index = tail[15:0];
        res.doorbell_write = 1'b1;
        res.doorbell_offset = bell_offset(2 * q);
        res.doorbell_value = nxt_tail[15:0];
      end else begin
        // last submitted entry, wrapping back from slot zero
        if (tail != 0) entry = tail - 1;
        else entry = (ring_len != 0) ? ring_len - 1 : 0;
        head = entry + 1;
        if (head >= ring_len) head = 0;
        res.slot_index = entry[15:0];
        if (it.seen_id == it.wanted_id) begin
          res.status = ST_COMPLETED;
          attempts = '0;
          res.doorbell_write = 1'b1;
          res.doorbell_offset = bell_offset(2 * q + 1);
          res.doorbell_value = head[15:0];
        end else begin
          if (attempts != COUNT_MAX) attempts = attempts + 1'b1;
          if (it.poll_limit != 0 && attempts > COUNT_W'(it.poll_limit)) begin
            res.status = ST_TIMEOUT;
            attempts = '0;
          end else begin
            res.status = ST_WAITING;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t exp_item;
    if (!rst_n) begin
      for (int i = 0; i <= MAX_IO_QUEUES; i++) ring_tails[i] = '0;
      attempts = '0;
      stride = STRIDE_RST;
      admin_size = ASIZE_RST;
      io_size = IOSIZE_RST;
      due_results.delete();
    end else begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result strobed with no item outstanding");
          errors++;
        end else begin
          exp_item = due_results.pop_front();
          check_field("status", 32'(exp_item.status), 32'(out_item.status));
          check_field("slot_index", 32'(exp_item.slot_index),
                      32'(out_item.slot_index));
          check_field("doorbell_write", 32'(exp_item.doorbell_write),
                      32'(out_item.doorbell_write));
          check_field("doorbell_offset", 32'(exp_item.doorbell_offset),
                      32'(out_item.doorbell_offset));
          check_field("doorbell_value", 32'(exp_item.doorbell_value),
                      32'(out_item.doorbell_value));
        end
      end
      if (start && !busy) due_results.push_back(predict_doorbell(in_item));
      if (cfg_we) begin
        case (cfg_index)
          CFG_DOORBELL_STRIDE:  stride = cfg_data[STRIDE_W-1:0];
          CFG_ADMIN_QUEUE_SIZE: admin_size = cfg_data[ASIZE_W-1:0];
          CFG_IO_QUEUE_SIZE:    io_size = cfg_data[IOSIZE_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= due_results.size();
    fail_count <= errors;
  end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench - tail doorbell manager regression
// directed corner items then sequences of submits and polls per queue under
// several register settings, random start gaps except last; checking in the checker
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import nqtd_pkg::*;

  localparam int MAX_Q        = 16;
  localparam int BELL_BASE    = 4096;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  // index past the register list, writes to it must have no effect
  localparam logic [CFGIDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            in_item = '0;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_we = 1'b0;
  logic [CFGIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  int                  fail_count;
  int                  pending;
  int                  cycles = 0;

  nvme_queue_tail_doorbell_manager #(
    .MAX_IO_QUEUES(MAX_Q),
    .DOORBELL_BASE(BELL_BASE)
  ) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  doorbell_checker #(
    .MAX_IO_QUEUES(MAX_Q),
    .DOORBELL_BASE(BELL_BASE)
  ) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic f, logic [4:0] q, logic [15:0] wanted,
                                       logic [15:0] seen, logic [15:0] limit);
    in_item_t it;
    it.func = f;
    it.queue_number = q;
    it.wanted_id = wanted;
    it.seen_id = seen;
    it.poll_limit = limit;
    return it;
  endfunction

  // holds start until the item is taken, optionally after a short gap
  task automatic issue_item(in_item_t it, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_reg(logic [CFGIDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_registers(int unsigned bell_stride, int unsigned admin_len,
                               int unsigned io_len);
    write_reg(CFG_SPARE_INDEX, CFG_W'($urandom));
    write_reg(CFG_DOORBELL_STRIDE, CFG_W'(bell_stride));
    write_reg(CFG_ADMIN_QUEUE_SIZE, CFG_W'(admin_len));
    write_reg(CFG_IO_QUEUE_SIZE, CFG_W'(io_len));
    cfg_we <= 1'b0;
  endtask

  // waits for every outstanding result, then lets the pipeline drain
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly a submit followed by polls on the same queue, some stray items
  task automatic run_sequences(int n_items, bit gaps);
    int          sent;
    int          polls;
    logic [4:0]  q;
    logic [15:0] limit;
    logic [15:0] wanted;
    logic [15:0] seen;
    bit          matched;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 15) begin
        issue_item(mk_item(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                           16'($urandom), 16'($urandom), 16'($urandom)), gaps);
        sent++;
      end else begin
        q = 5'($urandom_range(0, MAX_Q));
        case ($urandom_range(0, 3))
          0:       limit = '0;
          3:       limit = 16'($urandom);
          default: limit = 16'($urandom_range(1, 3));
        endcase
        polls = $urandom_range(0, 4);
        matched = ($urandom_range(0, 9) < 7);
        issue_item(mk_item(FUNC_SUBMIT, q, 16'($urandom), 16'($urandom), limit), gaps);
        sent++;
        for (int i = 0; i < polls; i++) begin
          wanted = 16'($urandom);
          seen = 16'($urandom);
          if (i == polls - 1 && matched) seen = wanted;
          else if (seen == wanted) seen = ~wanted;
          issue_item(mk_item(FUNC_POLL, q, wanted, seen, limit), gaps);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    issue_item(mk_item(FUNC_SUBMIT, 5'd0, 16'h0000, 16'h0000, 16'h0000), 0);
    issue_item(mk_item(FUNC_POLL, 5'd0, 16'h0000, 16'h0000, 16'h0000), 0);
    issue_item(mk_item(FUNC_SUBMIT, 5'(MAX_Q), 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
    issue_item(mk_item(FUNC_POLL, 5'(MAX_Q), 16'hFFFF, 16'hFFFF, 16'h0000), 0);
    // queue out of range, refused
    issue_item(mk_item(FUNC_SUBMIT, 5'(MAX_Q + 1), 16'h1234, 16'h1234, 16'h0000), 0);
    issue_item(mk_item(FUNC_POLL, 5'd31, 16'hFFFF, 16'h0000, 16'h0001), 0);
    // poll of an empty ring wraps back to the last entry; timeout after the limit
    issue_item(mk_item(FUNC_POLL, 5'd1, 16'h0001, 16'h0002, 16'h0000), 0);
    issue_item(mk_item(FUNC_POLL, 5'd1, 16'h0001, 16'h0002, 16'h0001), 0);
    issue_item(mk_item(FUNC_POLL, 5'd2, 16'h8000, 16'h0000, 16'hFFFF), 0);
    issue_item(mk_item(FUNC_POLL, 5'd2, 16'h8000, 16'h8000, 16'hFFFF), 0);
    issue_item(mk_item(FUNC_POLL, 5'd3, 16'h00FF, 16'hFF00, 16'h0001), 0);
    issue_item(mk_item(FUNC_POLL, 5'd3, 16'h00FF, 16'hFF00, 16'h0001), 0);
    // a submit must not disturb the attempt count
    issue_item(mk_item(FUNC_POLL, 5'd4, 16'h5555, 16'hAAAA, 16'h0002), 0);
    issue_item(mk_item(FUNC_SUBMIT, 5'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
    issue_item(mk_item(FUNC_POLL, 5'd4, 16'h5555, 16'hAAAA, 16'h0002), 0);
    issue_item(mk_item(FUNC_POLL, 5'd4, 16'h5555, 16'hAAAA, 16'h0002), 0);
    run_sequences(130, 1);
    settle();

    // rings of one and zero entries, widest stride; older tails now exceed the ring
    set_registers(2047, 1, 0);
    issue_item(mk_item(FUNC_SUBMIT, 5'd0, 16'h0000, 16'h0000, 16'h0000), 0);
    issue_item(mk_item(FUNC_POLL, 5'd0, 16'h0042, 16'h0042, 16'h0000), 0);
    issue_item(mk_item(FUNC_SUBMIT, 5'd5, 16'h0000, 16'h0000, 16'h0000), 0);
    issue_item(mk_item(FUNC_POLL, 5'd5, 16'h0007, 16'h0007, 16'h0000), 0);
    issue_item(mk_item(FUNC_POLL, 5'd9, 16'h0007, 16'h0008, 16'h0000), 0);
    issue_item(mk_item(FUNC_SUBMIT, 5'(MAX_Q), 16'h0000, 16'h0000, 16'h0000), 0);
    run_sequences(120, 1);
    settle();

    set_registers(1024, 2, 2);
    run_sequences(150, 1);
    settle();

    set_registers($urandom_range(4, 1024), 4096, 65536);
    run_sequences(150, 1);
    settle();

    // all-zero stride and all-ones sizes
    set_registers(0, 8191, 131071);
    run_sequences(150, 1);
    settle();

    // closing stretch with back-to-back items
    set_registers(4, 3, 5);
    run_sequences(150, 0);
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
